/* rtl/iidl_pkg.sv */
// shared types and constants for the indexed insert/delete list
`default_nettype none

package iidl_pkg;

    localparam int unsigned KIND_W       = 3;
    localparam int unsigned POS_W        = 8;
    localparam int unsigned VAL_W        = 32;
    localparam int unsigned STAT_W       = 2;
    localparam int unsigned CNT_W        = 8;
    localparam int unsigned DEF_CAPACITY = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ   = 3'd0,
        KIND_FRONT  = 3'd1,
        KIND_END    = 3'd2,
        KIND_AT     = 3'd3,
        KIND_DELETE = 3'd4
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic               shift_up;
        logic               shift_down;
        logic [POS_W-1:0]   pos;
        logic [VAL_W-1:0]   value;
    } t_cell_cmd;

    // per-beat result fields from the control unit
    typedef struct packed {
        logic               hit;
        t_status            status;
        logic [CNT_W-1:0]   entry_count;
    } t_ctrl_res;

endpackage

`default_nettype wire

/* rtl/indexed_insert_delete_list.sv */
// result: an accepted input beat's result beat is registered in the output register
// throughput: one beat per cycle while results are taken; every operation is a single parallel step of the cell row
// the output register lets a new beat in when it is empty or when the held result is taken in the same cycle
// reset: synchronous active low, clears the entry count and the output valid
// slot contents are not cleared; only slots below the entry count are ever read
`default_nettype none

module indexed_insert_delete_list import iidl_pkg::*; #(
    parameter int unsigned CAPACITY = DEF_CAPACITY
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [KIND_W-1:0]  i_kind,
    input  wire logic [POS_W-1:0]   i_position,
    input  wire logic [VAL_W-1:0]   i_value,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [VAL_W-1:0]        o_read_value,
    output logic                    o_hit,
    output logic [STAT_W-1:0]       o_status,
    output logic [CNT_W-1:0]        o_entry_count
);

    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    logic             w_exec;
    t_cell_cmd        w_cmd;
    t_ctrl_res        w_res;
    logic [VAL_W-1:0] w_slot [CAPACITY];
    logic [VAL_W-1:0] w_tap  [CAPACITY];
    logic [VAL_W-1:0] w_rd;

    // output register state
    logic               r_out_valid;
    logic [VAL_W-1:0]   r_read_value;
    logic               r_hit;
    logic [STAT_W-1:0]  r_status;
    logic [CNT_W-1:0]   r_entry_count;

    // a beat enters when the output register is empty or being drained
    assign o_in_ready = i_rst_n & (~r_out_valid | i_out_ready);
    assign w_exec     = i_in_valid & o_in_ready;

    iidl_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_exec     (w_exec),
        .i_kind     (i_kind),
        .i_position (i_position),
        .i_value    (i_value),
        .o_cmd      (w_cmd),
        .o_res      (w_res)
    );

    // row of slots; on insert each cell above the position takes its lower
    // neighbor, on delete each cell at or above it takes its upper neighbor
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VAL_W-1:0] w_lower;
        logic [VAL_W-1:0] w_upper;

        if (g == 0) begin : g_first
            assign w_lower = '0;
        end else begin : g_mid_lo
            assign w_lower = w_slot[g-1];
        end

        // the top cell has no upper neighbor and keeps its own value
        if (g == CAPACITY - 1) begin : g_last
            assign w_upper = w_slot[g];
        end else begin : g_mid_hi
            assign w_upper = w_slot[g+1];
        end

        iidl_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .o_slot  (w_slot[g]),
            .o_tap   (w_tap[g])
        );
    end

    // read bus: or of the cell taps, at most one of which is nonzero
    always_comb begin
        w_rd = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_rd = w_rd | w_tap[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload; a miss or any non-read reports the all-ones value
    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_read_value  <= w_res.hit ? w_rd : MISS_VALUE;
            r_hit         <= w_res.hit;
            r_status      <= w_res.status;
            r_entry_count <= w_res.entry_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_read_value;
    assign o_hit         = r_hit;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;

endmodule

`default_nettype wire

/* rtl/iidl_cell.sv */
// one slot of the list row: hold, take from a neighbor, or load a new value
`default_nettype none

module iidl_cell import iidl_pkg::*; #(
    parameter int unsigned IDX = 0
) (
    input  wire logic               i_clk,
    input  wire t_cell_cmd          i_cmd,
    input  wire logic [VAL_W-1:0]   i_lower,
    input  wire logic [VAL_W-1:0]   i_upper,
    output logic      [VAL_W-1:0]   o_slot,
    output logic      [VAL_W-1:0]   o_tap
);

    localparam logic [POS_W-1:0] IDX_P = POS_W'(IDX);

    logic [VAL_W-1:0] r_slot;
    logic [VAL_W-1:0] n_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_cmd.shift_up) begin
            if (IDX_P > i_cmd.pos) begin
                n_slot = i_lower;
            end else if (IDX_P == i_cmd.pos) begin
                n_slot = i_cmd.value;
            end
        end else if (i_cmd.shift_down) begin
            if (IDX_P >= i_cmd.pos) begin
                n_slot = i_upper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_slot = r_slot;
    // only the addressed cell contributes to the read bus
    assign o_tap  = (IDX_P == i_cmd.pos) ? r_slot : '0;

endmodule

`default_nettype wire

/* rtl/iidl_ctrl.sv */
// operation decode, range and full checks, and the entry count register
`default_nettype none

module iidl_ctrl import iidl_pkg::*; #(
    parameter int unsigned CAPACITY = DEF_CAPACITY
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_exec,
    input  wire logic [KIND_W-1:0]  i_kind,
    input  wire logic [POS_W-1:0]   i_position,
    input  wire logic [VAL_W-1:0]   i_value,
    output t_cell_cmd               o_cmd,
    output t_ctrl_res               o_res
);

    localparam logic [CNT_W-1:0] CAP_W = CNT_W'(CAPACITY);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] w_after;
    logic [POS_W-1:0] w_pos;
    logic             w_ins_req;
    logic             w_ins_ok;
    logic             w_del_ok;
    t_status          w_status;
    logic             w_hit;

    always_comb begin
        w_ins_req = 1'b0;
        w_ins_ok  = 1'b0;
        w_del_ok  = 1'b0;
        w_hit     = 1'b0;
        w_status  = ST_DONE;
        w_pos     = i_position;
        unique case (t_kind'(i_kind))
            KIND_READ: begin
                if (i_position < r_count) begin
                    w_hit = 1'b1;
                end else begin
                    w_status = ST_RANGE;
                end
            end
            KIND_FRONT: begin
                w_ins_req = 1'b1;
                w_pos     = '0;
            end
            KIND_END: begin
                w_ins_req = 1'b1;
                w_pos     = r_count;
            end
            KIND_AT: begin
                w_ins_req = 1'b1;
            end
            KIND_DELETE: begin
                if (i_position >= r_count) begin
                    w_status = ST_RANGE;
                end else begin
                    w_del_ok = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // position check wins over the full check
        if (w_ins_req) begin
            priority if (w_pos > r_count) begin
                w_status = ST_RANGE;
            end else if (r_count >= CAP_W) begin
                w_status = ST_FULL;
            end else begin
                w_ins_ok = 1'b1;
            end
        end

        w_after = r_count;
        if (w_ins_ok) begin
            w_after = CNT_W'(r_count + 1'b1);
        end else if (w_del_ok) begin
            w_after = CNT_W'(r_count - 1'b1);
        end
        n_count = i_exec ? w_after : r_count;

        o_cmd.shift_up   = i_exec & w_ins_ok;
        o_cmd.shift_down = i_exec & w_del_ok;
        o_cmd.pos        = w_pos;
        o_cmd.value      = i_value;

        o_res.hit         = w_hit;
        o_res.status      = w_status;
        o_res.entry_count = w_after;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

/* rtl/iidl_checker.sv */
// port-level checks for the indexed insert/delete list, bound to the top level
`default_nettype none

module iidl_checker import iidl_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               o_in_ready,
    input  wire logic [KIND_W-1:0]  i_kind,
    input  wire logic               o_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic [VAL_W-1:0]   o_read_value,
    input  wire logic               o_hit,
    input  wire logic [STAT_W-1:0]  o_status
);

    // every accepted beat shows up as a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted beat produced no result");

    // anything other than a read reports a miss
    a_nonread_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_kind != KIND_READ)
        |=> (!o_hit && o_read_value == '1))
        else $error("non-read beat reported a hit or a value");

    // a front insert can never be out of range
    a_front_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_kind == KIND_FRONT) |=> (o_status != ST_RANGE))
        else $error("front insert reported a range error");

    // an empty output register never blocks the input once out of reset
    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !o_out_valid) |-> o_in_ready)
        else $error("input stalled with no result pending");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready)
        |=> (o_out_valid && $stable(o_read_value) && $stable(o_status) && $stable(o_hit)))
        else $error("stalled result changed");

endmodule

bind indexed_insert_delete_list iidl_checker u_iidl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_kind       (i_kind),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_read_value (o_read_value),
    .o_hit        (o_hit),
    .o_status     (o_status)
);

`default_nettype wire

/* verif/testbench.sv */
// self-checking testbench for the indexed insert/delete list
`timescale 1ns / 1ps

module testbench;
    import iidl_pkg::*;

    localparam int unsigned CAPACITY    = DEF_CAPACITY;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          MAX_REPORTS = 10;

    // one expected result beat
    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic             hit;
        t_status          status;
        logic [CNT_W-1:0] entry_count;
    } t_list_result;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_in_valid    = 1'b0;
    logic [KIND_W-1:0] i_kind        = '0;
    logic [POS_W-1:0]  i_position    = '0;
    logic [VAL_W-1:0]  i_value       = '0;
    logic              i_out_ready   = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [VAL_W-1:0]  o_read_value;
    logic              o_hit;
    logic [STAT_W-1:0] o_status;
    logic [CNT_W-1:0]  o_entry_count;

    // shadow copy of the list contents and length
    logic [VAL_W-1:0] list_slots [CAPACITY];
    int unsigned      list_count = 0;

    // results still owed by the block, oldest first
    t_list_result pending_results [$];
    t_list_result oldest;
    int           mismatches     = 0;
    int           cycle_count    = 0;
    // percent of cycles in which each side holds off
    int           send_idle_pct  = 0;
    int           recv_idle_pct  = 0;

    indexed_insert_delete_list #(
        .CAPACITY      (CAPACITY)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_value  (o_read_value),
        .o_hit         (o_hit),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("indexed_insert_delete_list: mismatch");
            $finish;
        end
    end

    // result side stalls at random
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // apply one operation to the shadow list and return the beat it should produce
    function automatic t_list_result apply_list_op(logic [KIND_W-1:0] kind,
                                                   logic [POS_W-1:0] pos,
                                                   logic [VAL_W-1:0] value);
        t_list_result res;
        int           ins_pos;
        int           k;
        res.read_value = '1;
        res.hit        = 1'b0;
        res.status     = ST_DONE;
        ins_pos        = -1;
        case (kind)
            KIND_READ: begin
                if (pos < list_count) begin
                    res.read_value = list_slots[pos];
                    res.hit        = 1'b1;
                end else begin
                    res.status = ST_RANGE;
                end
            end
            KIND_FRONT:  ins_pos = 0;
            KIND_END:    ins_pos = list_count;
            KIND_AT:     ins_pos = pos;
            KIND_DELETE: begin
                if (pos >= list_count) begin
                    res.status = ST_RANGE;
                end else begin
                    for (k = pos; k + 1 < list_count; k++)
                        list_slots[k] = list_slots[k + 1];
                    list_count--;
                end
            end
            default: ;  // unused kinds leave everything alone
        endcase
        if (ins_pos >= 0) begin
            // a bad position wins over a full list
            if (ins_pos > list_count) begin
                res.status = ST_RANGE;
            end else if (list_count >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                for (k = list_count; k > ins_pos; k--)
                    list_slots[k] = list_slots[k - 1];
                list_slots[ins_pos] = value;
                list_count++;
            end
        end
        res.entry_count = CNT_W'(list_count);
        return res;
    endfunction

    // check each result beat against the oldest expectation, then log new input beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result beat: value=%h hit=%b status=%0d count=%0d",
                                 o_read_value, o_hit, o_status, o_entry_count);
                end else begin
                    oldest = pending_results.pop_front();
                    if (o_read_value !== oldest.read_value || o_hit !== oldest.hit ||
                        o_status !== oldest.status || o_entry_count !== oldest.entry_count) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $write("result differs: expected value=%h hit=%b status=%0d count=%0d,",
                                   oldest.read_value, oldest.hit, oldest.status,
                                   oldest.entry_count);
                            $display(" got value=%h hit=%b status=%0d count=%0d",
                                     o_read_value, o_hit, o_status, o_entry_count);
                        end
                    end
                end
            end
            if (i_in_valid && o_in_ready)
                pending_results.push_back(apply_list_op(i_kind, i_position, i_value));
        end
    end

    // present one operation beat and hold it until it is taken; valid stays high afterward
    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_position <= pos;
        i_value    <= value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // stop sending and wait for every owed result
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // reads, deletes and a bad insert on an empty list, then the first append
    task automatic test_empty_list();
        send_op(KIND_READ, 8'd0, 32'h0);
        send_op(KIND_READ, 8'd255, 32'h0);
        send_op(KIND_DELETE, 8'd0, 32'h0);
        send_op(KIND_DELETE, 8'd255, 32'h0);
        send_op(KIND_AT, 8'd1, 32'h5555_5555);
        // position equal to the count appends
        send_op(KIND_AT, 8'd0, 32'h8000_0000);
        send_op(KIND_READ, 8'd0, 32'h0);
        drain_results();
    endtask

    // every insert form and a delete in the middle and at the tail
    task automatic test_insert_positions();
        send_op(KIND_FRONT, 8'd0, 32'h7FFF_FFFF);
        send_op(KIND_END, 8'd0, 32'hFFFF_FFFF);
        send_op(KIND_AT, 8'd1, 32'h0000_0000);
        send_op(KIND_AT, 8'd4, 32'h1234_5678);
        send_op(KIND_READ, 8'd1, 32'h0);
        send_op(KIND_READ, 8'd4, 32'h0);
        send_op(KIND_DELETE, 8'd1, 32'hAAAA_AAAA);
        send_op(KIND_DELETE, 8'd3, 32'h0);
        send_op(KIND_READ, 8'd3, 32'h0);
        drain_results();
    endtask

    // fill to capacity, then probe full and out-of-range cases
    task automatic test_full_list();
        int fill;
        int k;
        fill = CAPACITY - list_count;
        for (k = 0; k < fill; k++)
            send_op(KIND_END, 8'd0, $urandom);
        send_op(KIND_FRONT, 8'd0, 32'hDEAD_BEEF);
        send_op(KIND_END, 8'd0, 32'hDEAD_BEEF);
        send_op(KIND_AT, POS_W'(CAPACITY), 32'hDEAD_BEEF);
        // bad position reported even though the list is full
        send_op(KIND_AT, POS_W'(CAPACITY + 1), 32'hDEAD_BEEF);
        send_op(KIND_READ, POS_W'(CAPACITY - 1), 32'h0);
        send_op(KIND_READ, POS_W'(CAPACITY), 32'h0);
        send_op(KIND_DELETE, 8'd0, 32'h0);
        send_op(KIND_DELETE, POS_W'(CAPACITY - 1), 32'h0);
        send_op(KIND_DELETE, POS_W'(CAPACITY - 2), 32'h0);
        drain_results();
    endtask

    // kinds five to seven change nothing
    task automatic test_unused_kinds();
        send_op(3'd5, 8'd0, 32'h0);
        send_op(3'd6, 8'd255, 32'hFFFF_FFFF);
        send_op(3'd7, 8'd3, $urandom);
        send_op(KIND_READ, 8'd0, 32'h0);
        drain_results();
    endtask

    // random traffic that swings the list between empty and full
    task automatic test_random_traffic(input int n_items, input int s_idle, input int r_idle);
        int                counted;
        int                pick;
        bit                growing;
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  value;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        counted       = 0;
        growing       = 1'b1;
        while (counted < n_items) begin
            if (list_count >= CAPACITY)
                growing = 1'b0;
            else if (list_count == 0)
                growing = 1'b1;
            else if ($urandom_range(0, 99) < 2)
                growing = !growing;
            pick = $urandom_range(0, 99);
            if (pick < 2)
                kind = KIND_W'($urandom_range(5, 7));
            else if (pick < 27)
                kind = KIND_READ;
            else if (growing)
                kind = (pick < 42) ? KIND_FRONT : (pick < 57) ? KIND_END :
                       (pick < 77) ? KIND_AT : KIND_DELETE;
            else
                kind = (pick < 35) ? KIND_FRONT : (pick < 43) ? KIND_END :
                       (pick < 53) ? KIND_AT : KIND_DELETE;
            // mostly positions near the live list, sometimes anywhere
            if ($urandom_range(0, 99) < 85)
                pos = POS_W'($urandom_range(0, list_count));
            else
                pos = POS_W'($urandom_range(0, 255));
            case ($urandom_range(0, 19))
                0:       value = 32'h7FFF_FFFF;
                1:       value = 32'h8000_0000;
                2:       value = 32'hFFFF_FFFF;
                3:       value = 32'h0000_0000;
                default: value = $urandom;
            endcase
            send_op(kind, pos, value);
            if (kind <= KIND_DELETE)
                counted++;
        end
        // sender holds off until the block has caught up
        drain_results();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 17;
        recv_idle_pct = 73;
        test_empty_list();
        test_insert_positions();
        test_full_list();
        test_unused_kinds();
        test_random_traffic(700, 17, 73);
        test_random_traffic(700, 73, 17);
        test_random_traffic(700, 0, 0);

        // idle wait to catch any stray beat
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("indexed_insert_delete_list: match");
        end else begin
            $display("indexed_insert_delete_list: mismatch");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/iidl_pkg.sv
rtl/iidl_cell.sv
rtl/iidl_ctrl.sv
rtl/indexed_insert_delete_list.sv
rtl/iidl_checker.sv
verif/testbench.sv
